@@ rtl/core/lws_pkg.sv @@
// Shared constants and types for the latency window statistics block.
package lws_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int DEV_W    = 13;
    localparam int SQ_W     = 2 * SAMPLE_W;

    // Default ring depth
    localparam int WINDOW_DEPTH_DEF = 32;

    // Reset value of the lowest-sample tracker
    localparam logic [SAMPLE_W-1:0] LOWEST_RESET = '1;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_DIV  = 5'b00100,
        S_SQRT = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

endpackage

@@ rtl/core/lws_if.sv @@
// Valid/ready channel interfaces for samples in and statistics out.
interface lws_in_if;
    import lws_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface lws_out_if;
    import lws_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] highest;
    logic [SAMPLE_W-1:0] lowest;
    logic [DEV_W-1:0]    deviation;

    modport source (output valid, output average, output highest, output lowest,
                    output deviation, input ready);
    modport sink   (input valid, input average, input highest, input lowest,
                    input deviation, output ready);
endinterface

@@ rtl/core/latency_window_statistics_top.sv @@
// Top level of the latency window statistics block.
//
// Usage: one latency sample enters per transaction on the samples channel;
// each sample yields exactly one transaction on the stats channel carrying
// the halving running average, the highest and lowest samples since reset,
// and the deviation over the sample ring (floor square root of the summed
// squared gaps to the average divided by held count minus one).
// Sequence: after a sample is taken the block walks the held ring entries
// through one RAM read port and one 12x12 squarer, then runs a bit-serial
// divider and a two-bits-per-step square root, and then loads the output
// register. With fewer than two samples held the walk, divider and square
// root are skipped. One sample is in flight at a time; samples.ready is
// high only while the block is idle.
// Reset clears the statistics, the ring count and the output valid flag; the
// ring RAM itself is not cleared, since only written entries are ever read.
// A stalled stats receiver holds the result in the output register; the
// next sample is still taken, and its result waits until that slot frees.
module latency_window_statistics_top #(
    parameter int WINDOW_DEPTH = lws_pkg::WINDOW_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    lws_in_if.sink           samples,
    lws_out_if.source        stats
);
    import lws_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SQ_W + ADDR_W;
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    // Control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [ADDR_W-1:0]   ovw_reg, ovw_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                p1_reg, p1_next;
    logic                p2_reg, p2_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;

    // Statistics state
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [SAMPLE_W-1:0] high_reg, high_next;
    logic [SAMPLE_W-1:0] low_reg, low_next;
    logic [DEV_W-1:0]    dev_reg, dev_next;

    // Datapath registers
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    dq_reg, dq_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_W:0]     srem_reg, srem_next;

    // Output register payload
    logic [SAMPLE_W-1:0] oavg_reg, oavg_next;
    logic [SAMPLE_W-1:0] ohigh_reg, ohigh_next;
    logic [SAMPLE_W-1:0] olow_reg, olow_next;
    logic [DEV_W-1:0]    odev_reg, odev_next;

    // RAM signals
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    // Combinational helpers
    logic                in_fire;
    logic [SAMPLE_W:0]   avg_sum;
    logic [CNT_W-1:0]    held_upd;
    logic                rd_issue;
    logic [SAMPLE_W-1:0] gap;
    logic [CNT_W-1:0]    divisor;
    logic [CNT_W:0]      div_trial;
    logic                div_take;
    logic [SUM_W-1:0]    dq_step;
    logic [CNT_W-1:0]    rem_step;
    logic [ROOT_W+2:0]   sq_trial_rem;
    logic [ROOT_W+2:0]   sq_trial_sub;
    logic                sq_take;
    logic [ROOT_W-1:0]   root_step;
    logic [ROOT_W:0]     srem_step;
    logic                out_free;

    lws_ram #(
        .DATA_W (SAMPLE_W),
        .DEPTH  (WINDOW_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (samples.sample),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign samples.ready  = (state_reg == S_IDLE);
    assign in_fire        = samples.valid && samples.ready;
    assign stats.valid     = out_valid_reg;
    assign stats.average   = oavg_reg;
    assign stats.highest   = ohigh_reg;
    assign stats.lowest    = olow_reg;
    assign stats.deviation = odev_reg;
    assign out_free        = !out_valid_reg || stats.ready;

    // Ring write position and updated count
    always_comb
    begin
        avg_sum = {1'b0, avg_reg} + {1'b0, samples.sample};
        if (held_reg < CNT_W'(WINDOW_DEPTH))
        begin
            ram_waddr = held_reg[ADDR_W-1:0];
            held_upd  = held_reg + 1'b1;
        end
        else
        begin
            ram_waddr = ovw_reg;
            held_upd  = held_reg;
        end
        ram_we = in_fire;
    end

    // Walk datapath: absolute gap to the average
    assign rd_issue = (rd_idx_reg != held_reg);
    assign gap      = (ram_rdata >= avg_reg) ? (ram_rdata - avg_reg) : (avg_reg - ram_rdata);

    // Restoring divider step
    assign divisor   = held_reg - 1'b1;
    assign div_trial = {rem_reg, dq_reg[SUM_W-1]};
    assign div_take  = (div_trial >= {1'b0, divisor});
    assign rem_step  = div_take ? CNT_W'(div_trial - {1'b0, divisor}) : div_trial[CNT_W-1:0];
    assign dq_step   = {dq_reg[SUM_W-2:0], div_take};

    // Square root step, two radicand bits per cycle
    assign sq_trial_rem = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sq_trial_sub = {1'b0, root_reg, 2'b01};
    assign sq_take      = (sq_trial_rem >= sq_trial_sub);
    assign srem_step    = sq_take ? (ROOT_W+1)'(sq_trial_rem - sq_trial_sub)
                                  : sq_trial_rem[ROOT_W:0];
    assign root_step    = {root_reg[ROOT_W-2:0], sq_take};

    // Sequencer and next-state logic
    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        ovw_next       = ovw_reg;
        rd_idx_next    = rd_idx_reg;
        p1_next        = 1'b0;
        p2_next        = 1'b0;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        avg_next       = avg_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        dev_next       = dev_reg;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        oavg_next      = oavg_reg;
        ohigh_next     = ohigh_reg;
        olow_next      = olow_reg;
        odev_next      = odev_reg;

        if (out_valid_reg && stats.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    // Statistics update
                    avg_next  = (avg_reg == '0) ? samples.sample : avg_sum[SAMPLE_W:1];
                    high_next = (samples.sample > high_reg) ? samples.sample : high_reg;
                    low_next  = (samples.sample < low_reg) ? samples.sample : low_reg;
                    held_next = held_upd;
                    if (held_reg == CNT_W'(WINDOW_DEPTH))
                    begin
                        ovw_next = (ovw_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : ovw_reg + 1'b1;
                    end
                    rd_idx_next = '0;
                    sum_next    = '0;
                    state_next  = (held_upd > CNT_W'(1)) ? S_SUM : S_OUT;
                end
            end

            S_SUM:
            begin
                // Pipeline: read, square, accumulate
                p1_next = rd_issue;
                p2_next = p1_reg;
                if (rd_issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (p1_reg)
                begin
                    sq_next = SQ_W'(gap) * SQ_W'(gap);
                end
                if (p2_reg)
                begin
                    sum_next = sum_reg + SUM_W'(sq_reg);
                end
                if (!rd_issue && !p1_reg && !p2_reg)
                begin
                    dq_next    = sum_reg;
                    rem_next   = '0;
                    step_next  = STEP_W'(SUM_W - 1);
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                dq_next  = dq_step;
                rem_next = rem_step;
                if (step_reg == '0)
                begin
                    rad_next   = RAD_W'(dq_step);
                    root_next  = '0;
                    srem_next  = '0;
                    step_next  = STEP_W'(ROOT_W - 1);
                    state_next = S_SQRT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            S_SQRT:
            begin
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                root_next = root_step;
                srem_next = srem_step;
                if (step_reg == '0)
                begin
                    dev_next   = root_step[DEV_W-1:0];
                    state_next = S_OUT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            S_OUT:
            begin
                // Load the output register once it is free
                if (out_free)
                begin
                    oavg_next      = avg_reg;
                    ohigh_next     = high_reg;
                    olow_next      = low_reg;
                    odev_next      = dev_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            ovw_reg       <= '0;
            rd_idx_reg    <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            avg_reg       <= '0;
            high_reg      <= '0;
            low_reg       <= LOWEST_RESET;
            dev_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            ovw_reg       <= ovw_next;
            rd_idx_reg    <= rd_idx_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            avg_reg       <= avg_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            dev_reg       <= dev_next;
        end
    end

    // Datapath and output payload registers
    always_ff @(posedge clk)
    begin
        sq_reg    <= sq_next;
        sum_reg   <= sum_next;
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        oavg_reg  <= oavg_next;
        ohigh_reg <= ohigh_next;
        olow_reg  <= olow_next;
        odev_reg  <= odev_next;
    end

endmodule

@@ rtl/core/lws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lws_ram #(
    parameter int DATA_W = 12,
    parameter int DEPTH  = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ dv/lws_stats_checker.sv @@
// Checker for the latency window statistics block: predicts each stats transaction and compares.
`timescale 1ns / 1ps

module lws_stats_checker #(
    parameter int DEPTH = lws_pkg::WINDOW_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lws_in_if    samples,
    lws_out_if   stats,
    output int   fail_count,
    output int   outstanding
);
    import lws_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [SAMPLE_W-1:0] highest;
        logic [SAMPLE_W-1:0] lowest;
        logic [DEV_W-1:0]    deviation;
    } stats_t;

    // Expected stats, oldest first
    stats_t expected_stats[$];

    // Predictor state
    logic [SAMPLE_W-1:0] avg_q;
    logic [SAMPLE_W-1:0] high_q;
    logic [SAMPLE_W-1:0] low_q;
    logic [SAMPLE_W-1:0] window_q [DEPTH];
    int                  wr_pos;
    int                  held;
    logic [DEV_W-1:0]    dev_q;

    // Exact floor square root, two bits per step
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Advance the predictor by one sample and return the stats it yields
    function automatic stats_t predict_stats(logic [SAMPLE_W-1:0] s);
        stats_t          r;
        longint unsigned sq_sum;
        int              gap;
        if (avg_q == '0)
            avg_q = s;
        else
            avg_q = SAMPLE_W'(({1'b0, avg_q} + {1'b0, s}) >> 1);
        if (s > high_q)
            high_q = s;
        if (s < low_q)
            low_q = s;

        // fill in order, then overwrite the oldest entry
        if (held < DEPTH)
        begin
            window_q[held] = s;
            held++;
        end
        else
        begin
            window_q[wr_pos] = s;
            wr_pos = (wr_pos + 1) % DEPTH;
        end

        // too few samples: keep the previous deviation
        if (held > 1)
        begin
            sq_sum = 0;
            for (int i = 0; i < held; i++)
            begin
                gap    = int'(window_q[i]) - int'(avg_q);
                sq_sum = sq_sum + longint'(gap) * longint'(gap);
            end
            sq_sum = sq_sum / longint'(held - 1);
            dev_q  = DEV_W'(floor_root(sq_sum));
        end

        r.average   = avg_q;
        r.highest   = high_q;
        r.lowest    = low_q;
        r.deviation = dev_q;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Compare accepted stats first, then log any accepted sample
    always @(posedge clk or negedge rst_n)
    begin
        stats_t want;
        stats_t got;
        if (!rst_n)
        begin
            avg_q  = '0;
            high_q = '0;
            low_q  = LOWEST_RESET;
            wr_pos = 0;
            held   = 0;
            dev_q  = '0;
            expected_stats.delete();
            outstanding = 0;
        end
        else
        begin
            if (stats.valid && stats.ready)
            begin
                got.average   = stats.average;
                got.highest   = stats.highest;
                got.lowest    = stats.lowest;
                got.deviation = stats.deviation;
                if (expected_stats.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected stats transaction avg=%0d",
                                              got.average));
                end
                else
                begin
                    want = expected_stats.pop_front();
                    if (got.average !== want.average)
                        report_mismatch($sformatf("average %0d, expected %0d",
                                                  got.average, want.average));
                    if (got.highest !== want.highest)
                        report_mismatch($sformatf("highest %0d, expected %0d",
                                                  got.highest, want.highest));
                    if (got.lowest !== want.lowest)
                        report_mismatch($sformatf("lowest %0d, expected %0d",
                                                  got.lowest, want.lowest));
                    if (got.deviation !== want.deviation)
                        report_mismatch($sformatf("deviation %0d, expected %0d",
                                                  got.deviation, want.deviation));
                end
            end
            if (samples.valid && samples.ready)
                expected_stats = {expected_stats, predict_stats(samples.sample)};
            outstanding = expected_stats.size();
        end
    end

    initial fail_count = 0;

endmodule

@@ dv/tb_latency_window_statistics_top.sv @@
// Testbench top: clock, reset, sample stimulus, stats back-pressure and the verdict.
`timescale 1ns / 1ps

module tb_latency_window_statistics_top;
    import lws_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 120;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   cycle_count;
    int   fail_count;
    int   outstanding;

    lws_in_if  samples_ch ();
    lws_out_if stats_ch ();

    latency_window_statistics_top #(
        .WINDOW_DEPTH(WINDOW_DEPTH_DEF)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(samples_ch),
        .stats  (stats_ch)
    );

    lws_stats_checker #(
        .DEPTH(WINDOW_DEPTH_DEF)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples_ch),
        .stats      (stats_ch),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout guard
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stats receiver: random stalls unless in the no-idle stretch
    initial
    begin
        stats_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            stats_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);
        end
    end

    // One sample transaction, with an optional random gap ahead of it
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 17)
            begin
                samples_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= s;
        do
            @(posedge clk);
        while (!samples_ch.ready);
    endtask

    // Hold off the sender until every expected stats transaction has come back
    task automatic wait_drained();
        samples_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [SAMPLE_W-1:0] directed_q[$];
        logic [SAMPLE_W-1:0] s;
        int                  mode;
        int                  center;
        rst_n             = 1'b0;
        no_idle           = 1'b0;
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first sample equal to the reset minimum, then zeros until the average drops to zero
        directed_q = {directed_q, 12'd4095};
        repeat (12) directed_q = {directed_q, 12'd0};
        // zero sample into a zero average, then a nonzero one taken outright
        directed_q = {directed_q, 12'd0, 12'd1, 12'd4095, 12'd2048, 12'd2047, 12'd1,
                      12'd4094, 12'd4095, 12'd0, 12'haaa, 12'h555};
        foreach (directed_q[i])
            send_sample(directed_q[i]);

        // Random part: shape of the values changes every few dozen transactions
        mode   = 0;
        center = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 48 == 0)
            begin
                mode   = $urandom_range(4);
                center = $urandom_range(4095);
            end
            no_idle = (i >= 700 && i < 1000);
            if (i == 400 || i == 1400)
                wait_drained();
            case (mode)
                0: s = SAMPLE_W'($urandom_range(4095));
                1: s = $urandom_range(1) ? 12'd4095 : 12'd0;
                2: s = SAMPLE_W'(center + $urandom_range(15) - 8);
                3: s = SAMPLE_W'($urandom_range(7));
                default: s = $urandom_range(1) ? SAMPLE_W'($urandom_range(4095))
                                               : SAMPLE_W'(4095 - $urandom_range(7));
            endcase
            send_sample(s);
        end
        samples_ch.valid <= 1'b0;
        no_idle = 1'b0;

        // Drain, then let the block settle
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lws_pkg.sv
rtl/core/lws_if.sv
rtl/core/lws_ram.sv
rtl/core/latency_window_statistics_top.sv
dv/lws_stats_checker.sv
dv/tb_latency_window_statistics_top.sv
